FILE: hdl/lss_pkg.sv
// ============================================================================
// lss_pkg - shared types and constants of the least-squares slope unit
// Field and accumulator widths, the sequencer states, the multiply phases and the status codes.
// ============================================================================
package lss_pkg;

   localparam int XWidth     = 16;  // frame index
   localparam int YWidth     = 24;  // sample, unsigned Q16.8
   localparam int CountWidth = 11;  // holds up to 1024 samples
   localparam int SxWidth    = 26;
   localparam int SyWidth    = 34;
   localparam int SxyWidth   = 50;
   localparam int SxxWidth   = 42;
   localparam int ProdWidth  = 60;  // widest of n*Sxy, Sx*Sy, n*Sxx, Sx*Sx
   localparam int MplWidth   = 26;  // widest multiplier operand (Sx)
   localparam int DenWidth   = 52;  // n*Sxx - Sx*Sx
   localparam int DivWidth   = 67;  // 100 * |numerator|
   localparam int AluWidth   = 68;
   localparam int StepWidth  = 7;   // counts up to DivWidth steps
   localparam int SlopeWidth = 32;

   localparam logic [SlopeWidth-1:0] SlopeMax = 32'h7FFF_FFFF;
   localparam logic [SlopeWidth-1:0] SlopeMin = 32'h8000_0000;

   typedef enum logic [1:0] {
      FIT_OK   = 2'd0,
      FIT_FEW  = 2'd1,
      FIT_FLAT = 2'd2
   } fit_status_type;

   typedef enum logic [1:0] {
      MUL_NXX = 2'd0,
      MUL_XX  = 2'd1,
      MUL_NXY = 2'd2,
      MUL_XY  = 2'd3
   } mul_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_PROD   = 4'd1,
      ST_ACC    = 4'd2,
      ST_EVAL   = 4'd3,
      ST_MUL    = 4'd4,
      ST_DEN    = 4'd5,
      ST_NUM    = 4'd6,
      ST_NEG    = 4'd7,
      ST_SCALE1 = 4'd8,
      ST_SCALE2 = 4'd9,
      ST_DIV    = 4'd10,
      ST_SAT    = 4'd11
   } lss_state_type;

endpackage

FILE: hdl/least_squares_slope_unit.sv
// ============================================================================
// least_squares_slope_unit - running least-squares slope of (x, y) samples
// Accumulates count, Sx, Sy, Sxy, Sxx and on the closing word computes
// 100 * (n*Sxy - Sx*Sy) / (n*Sxx - Sx*Sx) on one shared 68-bit adder.
// ============================================================================
// Usage:
//   Input channel: drive req_frame_index, req_sample_value, req_last_sample
//   and raise start; the word is taken at an edge where start is high and
//   busy is low. busy rises on the next cycle.
//   A word without req_last_sample keeps busy high through the product
//   register state, then the accumulate state; only then is a new word taken.
//   A word with req_last_sample ends the run: after accumulating, the unit
//   runs four shift-add multiplies (11, 26, 11 and 26 steps), adder steps
//   for the denominator, numerator, sign and x100 scale, a 67-step
//   restoring divide, all on the same adder, and a saturate step that raises
//   the result strobe rsp_valid. Short cuts (fewer than two samples, zero x
//   spread) end the run early with a result.
//   Result channel: rsp_valid is high for exactly one cycle with the fields;
//   the receiver cannot stall it. busy is low during that cycle.
//   Words beyond MAX_SAMPLES are dropped and flagged in rsp_samples_dropped.
//   Sums clear after each result.
//   Reset (synchronous, active high) clears all sums and returns to idle.
// ============================================================================
module least_squares_slope_unit
   import lss_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [XWidth-1:0]            req_frame_index,
   input  logic [YWidth-1:0]            req_sample_value,
   input  logic                         req_last_sample,
   output logic                         rsp_valid,
   output logic signed [SlopeWidth-1:0] rsp_slope_per_hundred,
   output logic [1:0]                   rsp_fit_status,
   output logic                         rsp_samples_dropped
);

   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_SAMPLES);

   // sequencer
   lss_state_type state_ff, state_in;
   mul_phase_type phase_ff, phase_in;
   logic [StepWidth-1:0] step_ff, step_in;

   // latched input word and its products
   logic [XWidth-1:0]         x_ff, x_in;
   logic [YWidth-1:0]         y_ff, y_in;
   logic                      last_ff, last_in;
   logic [XWidth+YWidth-1:0]  prod_xy_ff, prod_xy_in;
   logic [2*XWidth-1:0]       prod_xx_ff, prod_xx_in;

   // running sums
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SxWidth-1:0]    sum_x_ff, sum_x_in;
   logic [SyWidth-1:0]    sum_y_ff, sum_y_in;
   logic [SxyWidth-1:0]   sum_xy_ff, sum_xy_in;
   logic [SxxWidth-1:0]   sum_xx_ff, sum_xx_in;
   logic                  dropped_ff, dropped_in;

   // arithmetic working registers
   logic [ProdWidth-1:0] mcand_ff, mcand_in;
   logic [MplWidth-1:0]  mplier_ff, mplier_in;
   logic [ProdWidth-1:0] acc_ff, acc_in;
   logic [ProdWidth-1:0] t0_ff, t0_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic [ProdWidth-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [DivWidth-1:0]  num_ff, num_in;
   logic [DenWidth-1:0]  rem_ff, rem_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SlopeWidth-1:0] slope_ff, slope_in;
   fit_status_type        status_ff, status_in;
   logic                  drop_out_ff, drop_out_in;

   // shared adder / subtractor
   logic [AluWidth-1:0] alu_a, alu_b;
   logic                alu_sub;
   logic [AluWidth:0]   alu_sum;
   logic                alu_borrow;

   logic [ProdWidth-1:0] acc_step;
   logic [DenWidth:0]    trial;
   logic                 over_pos, over_neg;

   assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{AluWidth{1'b0}}, alu_sub};
   assign alu_borrow = alu_sub & ~alu_sum[AluWidth];

   // Next remainder candidate: bring down the next dividend bit.
   assign trial = {rem_ff, num_ff[DivWidth-1]};

   // Quotient beyond the signed 32-bit range.
   assign over_pos = |num_ff[DivWidth-1:SlopeWidth-1];
   assign over_neg = (|num_ff[DivWidth-1:SlopeWidth])
                     | (num_ff[SlopeWidth-1] & (|num_ff[SlopeWidth-2:0]));

   // Adder operand select: one use per state.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            alu_a = AluWidth'(acc_ff);
            alu_b = AluWidth'(mcand_ff);
         end
         ST_DEN, ST_NUM: begin
            alu_a   = AluWidth'(t0_ff);
            alu_b   = AluWidth'(acc_ff);
            alu_sub = 1'b1;
         end
         ST_NEG: begin
            alu_b   = AluWidth'(mag_ff);
            alu_sub = 1'b1;
         end
         ST_SCALE1: begin
            alu_a = AluWidth'(mag_ff) << 6;
            alu_b = AluWidth'(mag_ff) << 5;
         end
         ST_SCALE2: begin
            alu_a = AluWidth'(num_ff);
            alu_b = AluWidth'(mag_ff) << 2;
         end
         ST_DIV: begin
            alu_a   = AluWidth'(trial);
            alu_b   = AluWidth'(den_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   // Accumulator value after this multiply step.
   assign acc_step = mplier_ff[0] ? alu_sum[ProdWidth-1:0] : acc_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      prod_xy_in   = prod_xy_ff;
      prod_xx_in   = prod_xx_ff;
      count_in     = count_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_xy_in    = sum_xy_ff;
      sum_xx_in    = sum_xx_ff;
      dropped_in   = dropped_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      t0_in        = t0_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      slope_in     = slope_ff;
      status_in    = status_ff;
      drop_out_in  = drop_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = req_frame_index;
               y_in     = req_sample_value;
               last_in  = req_last_sample;
               state_in = ST_PROD;
            end
         end

         ST_PROD: begin
            prod_xy_in = x_ff * y_ff;
            prod_xx_in = x_ff * x_ff;
            state_in   = ST_ACC;
         end

         ST_ACC: begin
            // Drop the word once the run is full.
            if (count_ff < CountLimit) begin
               count_in  = count_ff + 1'b1;
               sum_x_in  = sum_x_ff + SxWidth'(x_ff);
               sum_y_in  = sum_y_ff + SyWidth'(y_ff);
               sum_xy_in = sum_xy_ff + SxyWidth'(prod_xy_ff);
               sum_xx_in = sum_xx_ff + SxxWidth'(prod_xx_ff);
            end else begin
               dropped_in = 1'b1;
            end
            state_in = last_ff ? ST_EVAL : ST_IDLE;
         end

         ST_EVAL: begin
            if (count_ff < CountWidth'(2)) begin
               slope_in     = '0;
               status_in    = FIT_FEW;
               drop_out_in  = dropped_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // start n * Sxx
               phase_in  = MUL_NXX;
               mcand_in  = ProdWidth'(sum_xx_ff);
               mplier_in = MplWidth'(count_ff);
               acc_in    = '0;
               step_in   = StepWidth'(CountWidth - 1);
               state_in  = ST_MUL;
            end
         end

         ST_MUL: begin
            // One shift-add step; on the last step hand over to the next phase.
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               unique case (phase_ff)
                  MUL_NXX: begin
                     t0_in     = acc_step;
                     phase_in  = MUL_XX;
                     mcand_in  = ProdWidth'(sum_x_ff);
                     mplier_in = MplWidth'(sum_x_ff);
                     acc_in    = '0;
                     step_in   = StepWidth'(SxWidth - 1);
                  end
                  MUL_XX: begin
                     state_in = ST_DEN;
                  end
                  MUL_NXY: begin
                     t0_in     = acc_step;
                     phase_in  = MUL_XY;
                     mcand_in  = ProdWidth'(sum_y_ff);
                     mplier_in = MplWidth'(sum_x_ff);
                     acc_in    = '0;
                     step_in   = StepWidth'(SxWidth - 1);
                  end
                  MUL_XY: begin
                     state_in = ST_NUM;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_DEN: begin
            // Denominator is never negative; zero means all x were equal.
            den_in = alu_sum[DenWidth-1:0];
            if (alu_sum[DenWidth-1:0] == '0) begin
               slope_in     = '0;
               status_in    = FIT_FLAT;
               drop_out_in  = dropped_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               phase_in  = MUL_NXY;
               mcand_in  = ProdWidth'(sum_xy_ff);
               mplier_in = MplWidth'(count_ff);
               acc_in    = '0;
               step_in   = StepWidth'(CountWidth - 1);
               state_in  = ST_MUL;
            end
         end

         ST_NUM: begin
            mag_in   = alu_sum[ProdWidth-1:0];
            neg_in   = alu_borrow;
            state_in = ST_NEG;
         end

         ST_NEG: begin
            if (neg_ff) begin
               mag_in = alu_sum[ProdWidth-1:0];
            end
            state_in = ST_SCALE1;
         end

         ST_SCALE1: begin
            num_in   = alu_sum[DivWidth-1:0];
            state_in = ST_SCALE2;
         end

         ST_SCALE2: begin
            num_in   = alu_sum[DivWidth-1:0];
            rem_in   = '0;
            step_in  = StepWidth'(DivWidth - 1);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // Restoring step: quotient bits shift in behind the dividend.
            if (!alu_borrow) begin
               rem_in = alu_sum[DenWidth-1:0];
            end else begin
               rem_in = trial[DenWidth-1:0];
            end
            num_in  = {num_ff[DivWidth-2:0], ~alu_borrow};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SAT;
            end
         end

         ST_SAT: begin
            if (!neg_ff) begin
               slope_in = over_pos ? SlopeMax : num_ff[SlopeWidth-1:0];
            end else begin
               slope_in = over_neg ? SlopeMin : (SlopeWidth'(0) - num_ff[SlopeWidth-1:0]);
            end
            status_in    = FIT_OK;
            drop_out_in  = dropped_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Clear the run once its result goes out.
      if (rsp_valid_in) begin
         count_in   = '0;
         sum_x_in   = '0;
         sum_y_in   = '0;
         sum_xy_in  = '0;
         sum_xx_in  = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= MUL_NXX;
         step_ff      <= '0;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         sum_xx_ff    <= sum_xx_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers: no reset needed.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      prod_xy_ff  <= prod_xy_in;
      prod_xx_ff  <= prod_xx_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      t0_ff       <= t0_in;
      den_ff      <= den_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      slope_ff    <= slope_in;
      status_ff   <= status_in;
      drop_out_ff <= drop_out_in;
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slope_per_hundred = slope_ff;
   assign rsp_fit_status        = status_ff;
   assign rsp_samples_dropped   = drop_out_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountLimit)
      else $error("sample count beyond capacity");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0)
      else $error("divide started with zero denominator");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status != FIT_OK |-> rsp_slope_per_hundred == '0)
      else $error("nonzero slope reported with failed fit");

endmodule

FILE: tb/sv/least_squares_slope_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// least_squares_slope_unit_tb - self-checking bench for the slope unit
// Feeds runs of (frame index, sample) words through the command port and
// predicts each run's slope, status and drop flag in exact wide integers.
// Every strobed result is checked against the oldest prediction.
// ============================================================================
module least_squares_slope_unit_tb
   import lss_pkg::*;
();

   localparam int MaxSamples = 1024;

   // run shapes for the random part
   localparam int RUN_SPREAD = 0;  // x and y anywhere in range
   localparam int RUN_NARROW = 1;  // x over two adjacent frames, y mostly at extremes
   localparam int RUN_FLAT   = 2;  // every x equal
   localparam int RUN_STEADY = 3;  // every y equal

   typedef struct {
      logic [XWidth-1:0] x;
      logic [YWidth-1:0] y;
      logic              last;
   } sample_word_type;

   typedef struct {
      logic signed [SlopeWidth-1:0] slope;
      fit_status_type               status;
      logic                         dropped;
   } fit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [XWidth-1:0] req_frame_index = '0;
   logic [YWidth-1:0] req_sample_value = '0;
   logic req_last_sample = 1'b0;
   logic rsp_valid;
   logic signed [SlopeWidth-1:0] rsp_slope_per_hundred;
   logic [1:0] rsp_fit_status;
   logic rsp_samples_dropped;

   // words waiting to be sent, and fits predicted but not yet returned
   sample_word_type word_backlog[$];
   fit_result_type  pending_fits[$];

   int sender_idle_pct = 0;
   int error_count = 0;

   // running sums of the open run, kept in step with the unit's accumulators
   logic [CountWidth-1:0] run_count = '0;
   logic [SxWidth-1:0]    run_sx = '0;
   logic [SyWidth-1:0]    run_sy = '0;
   logic [SxyWidth-1:0]   run_sxy = '0;
   logic [SxxWidth-1:0]   run_sxx = '0;
   logic                  run_dropped = 1'b0;

   least_squares_slope_unit #(.MAX_SAMPLES(MaxSamples)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_frame_index(req_frame_index),
      .req_sample_value(req_sample_value),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid),
      .rsp_slope_per_hundred(rsp_slope_per_hundred),
      .rsp_fit_status(rsp_fit_status),
      .rsp_samples_dropped(rsp_samples_dropped)
   );

   always #1 clock = ~clock;

   // Fold one accepted word into the run. On the closing word, compute the
   // slope exactly: 100 * (n*Sxy - Sx*Sy) / (n*Sxx - Sx*Sx), truncated toward
   // zero and clamped to 32 bits, then clear the sums.
   task automatic fold_sample(input logic [XWidth-1:0] x, input logic [YWidth-1:0] y,
                              input logic last);
      logic [127:0] n, den, prod_a, prod_b, mag, scaled;
      fit_result_type fit;
      if (run_count < MaxSamples) begin
         run_count = run_count + 1'b1;
         run_sx = run_sx + SxWidth'(x);
         run_sy = run_sy + SyWidth'(y);
         run_sxy = run_sxy + SxyWidth'(x) * SxyWidth'(y);
         run_sxx = run_sxx + SxxWidth'(x) * SxxWidth'(x);
      end else begin
         // run is full: drop the word but remember it
         run_dropped = 1'b1;
      end
      if (last) begin
         n = 128'(run_count);
         fit.slope = '0;
         fit.dropped = run_dropped;
         if (n < 128'd2) begin
            fit.status = FIT_FEW;
         end else begin
            den = n * 128'(run_sxx) - 128'(run_sx) * 128'(run_sx);
            if (den == '0) begin
               fit.status = FIT_FLAT;
            end else begin
               fit.status = FIT_OK;
               prod_a = n * 128'(run_sxy);
               prod_b = 128'(run_sx) * 128'(run_sy);
               mag = (prod_a >= prod_b) ? prod_a - prod_b : prod_b - prod_a;
               scaled = (mag * 128'd100) / den;
               if (prod_a >= prod_b)
                  fit.slope = (scaled > 128'(SlopeMax)) ? SlopeMax : scaled[SlopeWidth-1:0];
               else
                  fit.slope = (scaled > 128'(SlopeMin)) ? SlopeMin : -scaled[SlopeWidth-1:0];
            end
         end
         pending_fits.insert(pending_fits.size(), fit);
         run_count = '0;
         run_sx = '0;
         run_sy = '0;
         run_sxy = '0;
         run_sxx = '0;
         run_dropped = 1'b0;
      end
   endtask

   // Driver: take the word at an edge with start high and busy low, then
   // either present the next backlog word or drop start. Hold the
   // word steady while the unit is busy.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold: the unit has not taken this word yet
      end else begin
         if (start) begin
            fold_sample(req_frame_index, req_sample_value, req_last_sample);
            void'(word_backlog.pop_front());
         end
         if (word_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_frame_index <= word_backlog[0].x;
            req_sample_value <= word_backlog[0].y;
            req_last_sample <= word_backlog[0].last;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest predicted fit.
   always @(posedge clock) begin
      fit_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_fits.size() == 0) begin
            $display("%0t: unexpected result slope %0d status %0d dropped %0b", $time,
                     rsp_slope_per_hundred, rsp_fit_status, rsp_samples_dropped);
            error_count++;
         end else begin
            want = pending_fits.pop_front();
            if (rsp_slope_per_hundred !== want.slope) begin
               $display("%0t: slope expected %0d got %0d", $time, want.slope,
                        rsp_slope_per_hundred);
               error_count++;
            end
            if (rsp_fit_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_fit_status);
               error_count++;
            end
            if (rsp_samples_dropped !== want.dropped) begin
               $display("%0t: dropped flag expected %0b got %0b", $time, want.dropped,
                        rsp_samples_dropped);
               error_count++;
            end
         end
      end
   end

   task automatic send_word(input logic [XWidth-1:0] x, input logic [YWidth-1:0] y,
                            input logic last);
      sample_word_type w;
      w.x = x;
      w.y = y;
      w.last = last;
      word_backlog.insert(word_backlog.size(), w);
   endtask

   // Queue one run of len words; only the final word closes the run.
   task automatic queue_run(input int len, input int shape);
      logic [XWidth-1:0] base_x, x;
      logic [YWidth-1:0] base_y, y;
      logic step;
      base_x = XWidth'($urandom_range(0, 16'hFFFE));
      base_y = YWidth'($urandom);
      for (int i = 0; i < len; i++) begin
         x = XWidth'($urandom);
         y = YWidth'($urandom);
         case (shape)
            RUN_NARROW: begin
               // steepest slopes: y jumps with x across one frame
               step = 1'($urandom_range(1));
               x = base_x + XWidth'(step);
               y = ($urandom_range(3) != 0) ? {YWidth{step}} : y;
            end
            RUN_FLAT: x = base_x;
            RUN_STEADY: y = base_y;
            default: ;
         endcase
         send_word(x, y, i == len - 1);
      end
   endtask

   // Pause the stimulus until the backlog is sent and every fit is back.
   task automatic wait_drained();
      do @(posedge clock);
      while (word_backlog.size() != 0 || pending_fits.size() != 0);
   endtask

   initial begin
      int idle_plan[4];
      int queued, len, pick;
      idle_plan = '{0, 51, 0, 22};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed runs.
      // single sample: too few for a fit
      send_word('1, '1, 1'b1);
      // every x equal: zero spread
      send_word(16'd5, 24'd10, 1'b0);
      send_word(16'd5, 24'd200, 1'b0);
      send_word(16'd5, '1, 1'b1);
      // steepest rise and fall over one frame
      send_word(16'd0, '0, 1'b0);
      send_word(16'd1, '1, 1'b1);
      send_word(16'd0, '1, 1'b0);
      send_word(16'd1, '0, 1'b1);
      // widest x span
      send_word(16'd0, '1, 1'b0);
      send_word('1, '0, 1'b1);
      // fractional slopes truncate toward zero, both signs
      send_word(16'd0, 24'd0, 1'b0);
      send_word(16'd300, 24'd1, 1'b1);
      send_word(16'd0, 24'd1, 1'b0);
      send_word(16'd300, 24'd0, 1'b1);
      // flat line: slope exactly zero
      send_word(16'd1, 24'd77, 1'b0);
      send_word(16'd2, 24'd77, 1'b1);
      wait_drained();

      // Random runs in phases of different sender pacing. Overrun the
      // unit in the last phase: it fills up, then drops two words.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         if (phase == 3)
            queue_run(MaxSamples + 2, RUN_SPREAD);
         for (queued = 0; queued < 110; queued += len) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
            pick = $urandom_range(9);
            queue_run(len, (pick < 6) ? RUN_SPREAD :
                           (pick < 8) ? RUN_NARROW :
                           (pick == 8) ? RUN_FLAT : RUN_STEADY);
         end
         wait_drained();
      end

      // let any stray strobe show up before the verdict
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
